/* sv/reciprocal_poisson_scaling_assert.svh */
// assertion macros for the checker of this block
`ifndef RECIPROCAL_POISSON_SCALING_ASSERT_SVH
`define RECIPROCAL_POISSON_SCALING_ASSERT_SVH

// condition implies consequence in the same cycle
`define RPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("reciprocal_poisson_scaling check failed");

// condition implies consequence in the next cycle
`define RPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("reciprocal_poisson_scaling check failed");

`endif

/* sv/rps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;

  // default grid sizes
  localparam int unsigned GRID_FIRST_DEF  = 64;
  localparam int unsigned GRID_SECOND_DEF = 64;
  localparam int unsigned GRID_THIRD_DEF  = 64;

  // field and datapath widths
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned FREQ_W    = 12;
  localparam int unsigned COMP_W    = 16;
  localparam int unsigned ROW_W     = 3 * COMP_W;
  localparam int unsigned PROD_W    = 28;
  localparam int unsigned G_W       = 28;
  localparam int unsigned GABS_W    = 27;
  localparam int unsigned SQ_W      = 2 * GABS_W;
  localparam int unsigned G2_W      = SQ_W + 1;
  localparam int unsigned D_W       = G2_W + 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NUM_W     = 2 * DATA_W;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DK_W      = D_W + DIV_STEPS;

  // stream and register port widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 2 * DATA_W;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned ADDR_W      = 5;

  localparam logic [DATA_W-1:0] SCALE_RESET = 32'd205887;
  localparam logic [DATA_W-1:0] POS_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT   = 32'h8000_0000;

  // register map, one register every eight bytes
  typedef enum logic [1:0] {
    REG_ROW_ONE,
    REG_ROW_TWO,
    REG_ROW_THREE,
    REG_SCALE
  } cfg_reg_e;

  // index to signed frequency: one subtraction of the grid size
  function automatic logic signed [FREQ_W-1:0] wrap_freq(
    input logic [IDX_W-1:0] idx,
    input int unsigned      grid,
    input int unsigned      half
  );
    logic signed [FREQ_W-1:0] k;
    k = signed'(FREQ_W'(idx));
    if (32'(idx) >= half) begin
      k = k - signed'(FREQ_W'(grid));
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* sv/reciprocal_poisson_scaling.sv */
`timescale 1ns / 1ps
`default_nettype none
// throughput: one coefficient per cycle while the output is not stalled; the depth is set
//   by the restoring divider, one quotient bit per pipeline stage over 32 stages
// reset: clears all valid bits, lattice rows to zero, scale to its default
// stalls fill pipeline bubbles before input ready drops
module reciprocal_poisson_scaling #(
  parameter int unsigned GRID_FIRST  = rps_pkg::GRID_FIRST_DEF,
  parameter int unsigned GRID_SECOND = rps_pkg::GRID_SECOND_DEF,
  parameter int unsigned GRID_THIRD  = rps_pkg::GRID_THIRD_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // idx_first, idx_second, idx_third, re_in, im_in from bit 0 up
  input  wire logic [rps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // re_out, im_out from bit 0 up
  output logic [rps_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // saturated
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rps_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [rps_pkg::CFG_W-1:0]        pwdata,
  output logic [rps_pkg::CFG_W-1:0]             prdata,
  output logic                                  pready
);

  localparam int unsigned HALF_FIRST  = GRID_FIRST / 2;
  localparam int unsigned HALF_SECOND = GRID_SECOND / 2;
  localparam int unsigned HALF_THIRD  = GRID_THIRD / 2;
  localparam int unsigned DIV0        = 5;
  localparam int unsigned NST         = DIV0 + rps_pkg::DIV_STEPS + 2;
  localparam int unsigned OUT_ST      = NST - 1;

  localparam int unsigned IW = rps_pkg::IDX_W;
  localparam int unsigned DW = rps_pkg::DATA_W;

  // configuration registers
  logic [rps_pkg::ROW_W-1:0]  row_q [3];
  logic [DW-1:0]              scale_q;
  rps_pkg::cfg_reg_e          reg_sel;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = rps_pkg::cfg_reg_e'(paddr[rps_pkg::ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= '0;
      row_q[1] <= '0;
      row_q[2] <= '0;
      scale_q  <= rps_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        rps_pkg::REG_ROW_ONE:   row_q[0] <= pwdata[rps_pkg::ROW_W-1:0];
        rps_pkg::REG_ROW_TWO:   row_q[1] <= pwdata[rps_pkg::ROW_W-1:0];
        rps_pkg::REG_ROW_THREE: row_q[2] <= pwdata[rps_pkg::ROW_W-1:0];
        rps_pkg::REG_SCALE:     scale_q  <= pwdata[DW-1:0];
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_sel)
      rps_pkg::REG_ROW_ONE:   prdata = rps_pkg::CFG_W'(row_q[0]);
      rps_pkg::REG_ROW_TWO:   prdata = rps_pkg::CFG_W'(row_q[1]);
      rps_pkg::REG_ROW_THREE: prdata = rps_pkg::CFG_W'(row_q[2]);
      rps_pkg::REG_SCALE:     prdata = rps_pkg::CFG_W'(scale_q);
    endcase
  end

  // valid bits and ready chain, a stage takes data when empty or moving on
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_axis_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 0: unpack and wrap indices to frequencies
  logic signed [rps_pkg::FREQ_W-1:0] s_q [3];
  logic [DW-1:0]                     raw0_q [2];
  logic                              zero0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      s_q[0]    <= rps_pkg::wrap_freq(s_axis_tdata[IW-1:0], GRID_FIRST, HALF_FIRST);
      s_q[1]    <= rps_pkg::wrap_freq(s_axis_tdata[2*IW-1:IW], GRID_SECOND, HALF_SECOND);
      s_q[2]    <= rps_pkg::wrap_freq(s_axis_tdata[3*IW-1:2*IW], GRID_THIRD, HALF_THIRD);
      zero0_q   <= (s_axis_tdata[3*IW-1:0] == '0);
      raw0_q[0] <= s_axis_tdata[3*IW+DW-1:3*IW];
      raw0_q[1] <= s_axis_tdata[3*IW+2*DW-1:3*IW+DW];
    end
  end

  // stage 1: frequency times lattice component, per row and axis
  logic signed [rps_pkg::PROD_W-1:0] prod_q [3][3];
  logic [DW-1:0]                     raw1_q [2];
  logic                              zero1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= rps_pkg::PROD_W'(s_q[r]) *
                          rps_pkg::PROD_W'(signed'(row_q[r][rps_pkg::COMP_W*c +:
                                                             rps_pkg::COMP_W]));
        end
      end
      raw1_q  <= raw0_q;
      zero1_q <= zero0_q;
    end
  end

  // stage 2: sum rows into G components, keep magnitudes
  logic signed [rps_pkg::G_W-1:0] gsum [3];
  logic [rps_pkg::GABS_W-1:0]     gabs_q [3];
  logic [DW-1:0]                  raw2_q [2];
  logic                           zero2_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gsum[c] = rps_pkg::G_W'(prod_q[0][c]) + rps_pkg::G_W'(prod_q[1][c]) +
                rps_pkg::G_W'(prod_q[2][c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      for (int c = 0; c < 3; c++) begin
        gabs_q[c] <= gsum[c][rps_pkg::G_W-1] ? rps_pkg::GABS_W'(-gsum[c])
                                              : rps_pkg::GABS_W'(gsum[c]);
      end
      raw2_q  <= raw1_q;
      zero2_q <= zero1_q;
    end
  end

  // stage 3: square each component, split coefficient into sign and magnitude
  logic [rps_pkg::SQ_W-1:0] sq_q [3];
  logic [DW-1:0]            mag3_q [2];
  logic                     neg3_q [2];
  logic                     zero3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= {{rps_pkg::GABS_W{1'b0}}, gabs_q[c]} *
                   {{rps_pkg::GABS_W{1'b0}}, gabs_q[c]};
      end
      for (int l = 0; l < 2; l++) begin
        neg3_q[l] <= raw2_q[l][DW-1];
        mag3_q[l] <= raw2_q[l][DW-1] ? (~raw2_q[l] + DW'(1)) : raw2_q[l];
      end
      zero3_q <= zero2_q;
    end
  end

  // stage 4: |G|^2 and scaled numerators
  logic [rps_pkg::G2_W-1:0]  g2_q;
  logic [rps_pkg::NUM_W-1:0] num4_q [2];
  logic                      neg4_q [2];
  logic                      magz4_q [2];
  logic                      zero4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      g2_q <= rps_pkg::G2_W'(sq_q[0]) + rps_pkg::G2_W'(sq_q[1]) + rps_pkg::G2_W'(sq_q[2]);
      for (int l = 0; l < 2; l++) begin
        num4_q[l]  <= {{DW{1'b0}}, scale_q} * {{DW{1'b0}}, mag3_q[l]};
        magz4_q[l] <= (mag3_q[l] == '0);
      end
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // divider state, entry 0 is the overflow stage, entry j after j quotient bits
  logic [rps_pkg::D_W-1:0]       dv_d_q   [rps_pkg::DIV_STEPS+1];
  logic [rps_pkg::NUM_W-1:0]     dv_rem_q [rps_pkg::DIV_STEPS+1][2];
  logic [rps_pkg::DIV_STEPS-1:0] dv_quo_q [rps_pkg::DIV_STEPS+1][2];
  logic                          dv_ovf_q [rps_pkg::DIV_STEPS+1][2];
  logic                          dv_neg_q [rps_pkg::DIV_STEPS+1][2];
  logic                          dv_zl_q  [rps_pkg::DIV_STEPS+1][2];

  // stage 5: quotient of 2^32 or more saturates, zero parts short out
  logic [rps_pkg::D_W-1:0] dfull;
  assign dfull = {g2_q, 8'b0};

  always_ff @(posedge clk_i) begin
    if (rdy[DIV0] && v_q[DIV0-1]) begin
      dv_d_q[0] <= dfull;
      for (int l = 0; l < 2; l++) begin
        dv_rem_q[0][l] <= num4_q[l];
        dv_quo_q[0][l] <= '0;
        dv_ovf_q[0][l] <= rps_pkg::DK_W'(num4_q[l]) >=
                          (rps_pkg::DK_W'(dfull) << rps_pkg::DIV_STEPS);
        dv_neg_q[0][l] <= neg4_q[l];
        dv_zl_q[0][l]  <= zero4_q || magz4_q[l];
      end
    end
  end

  // restoring division, one quotient bit per stage from the top down
  for (genvar j = 0; j < rps_pkg::DIV_STEPS; j++) begin : g_div
    localparam int unsigned K = rps_pkg::DIV_STEPS - 1 - j;
    logic [rps_pkg::DK_W-1:0] dk;
    logic                     take [2];

    assign dk = rps_pkg::DK_W'(dv_d_q[j]) << K;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        take[l] = rps_pkg::DK_W'(dv_rem_q[j][l]) >= dk;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[DIV0+1+j] && v_q[DIV0+j]) begin
        dv_d_q[j+1] <= dv_d_q[j];
        for (int l = 0; l < 2; l++) begin
          dv_rem_q[j+1][l] <= take[l] ? (dv_rem_q[j][l] - dk[rps_pkg::NUM_W-1:0])
                                      : dv_rem_q[j][l];
          dv_quo_q[j+1][l] <= {dv_quo_q[j][l][rps_pkg::DIV_STEPS-2:0], take[l]};
          dv_ovf_q[j+1][l] <= dv_ovf_q[j][l];
          dv_neg_q[j+1][l] <= dv_neg_q[j][l];
          dv_zl_q[j+1][l]  <= dv_zl_q[j][l];
        end
      end
    end
  end

  // output stage: apply sign and clip
  logic [DW-1:0] res   [2];
  logic          clip  [2];
  logic [DW-1:0] res_q [2];
  logic          sat_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      priority if (dv_zl_q[rps_pkg::DIV_STEPS][l]) begin
        res[l]  = '0;
        clip[l] = 1'b0;
      end else if (dv_ovf_q[rps_pkg::DIV_STEPS][l]) begin
        res[l]  = dv_neg_q[rps_pkg::DIV_STEPS][l] ? rps_pkg::NEG_LIMIT : rps_pkg::POS_LIMIT;
        clip[l] = 1'b1;
      end else if (!dv_neg_q[rps_pkg::DIV_STEPS][l]) begin
        clip[l] = dv_quo_q[rps_pkg::DIV_STEPS][l][DW-1];
        res[l]  = clip[l] ? rps_pkg::POS_LIMIT : dv_quo_q[rps_pkg::DIV_STEPS][l];
      end else begin
        clip[l] = dv_quo_q[rps_pkg::DIV_STEPS][l] > rps_pkg::NEG_LIMIT;
        res[l]  = clip[l] ? rps_pkg::NEG_LIMIT
                          : (~dv_quo_q[rps_pkg::DIV_STEPS][l] + DW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_ST] && v_q[OUT_ST-1]) begin
      res_q <= res;
      sat_q <= clip[0] || clip[1];
    end
  end

  assign m_axis_tvalid = v_q[OUT_ST];
  assign m_axis_tdata  = {res_q[1], res_q[0]};
  assign m_axis_tuser  = sat_q;

endmodule
`default_nettype wire

/* sv/rps_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "reciprocal_poisson_scaling_assert.svh"
module rps_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic [rps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [rps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                             m_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic                             psel,
  input wire logic                             penable,
  input wire logic                             pwrite,
  input wire logic [rps_pkg::ADDR_W-1:0]       paddr,
  input wire logic [rps_pkg::CFG_W-1:0]        pwdata,
  input wire logic [rps_pkg::CFG_W-1:0]        prdata,
  input wire logic                             pready
);

  // a stalled result keeps its request up
  `RPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a stalled result keeps its payload
  `RPS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // an empty output stage never holds back the input
  `RPS_ASSERT_NOW(a_in_ready, !m_axis_tvalid, s_axis_tready)

  // the clip flag only comes with a limit value on one of the parts
  `RPS_ASSERT_NOW(a_sat_limit, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[31:0] == rps_pkg::POS_LIMIT ||
                  m_axis_tdata[31:0] == rps_pkg::NEG_LIMIT ||
                  m_axis_tdata[63:32] == rps_pkg::POS_LIMIT ||
                  m_axis_tdata[63:32] == rps_pkg::NEG_LIMIT)

endmodule

bind reciprocal_poisson_scaling rps_checker u_rps_checker (.*);
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned PHASES      = 9;

  // one expected potential coefficient
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
  } coeff_t;

  // poisson scaling predictor and queue of expected coefficients
  class poisson_board;
    logic [47:0] row_one, row_two, row_three;
    logic [31:0] scale;
    coeff_t      pending[$];

    function new();
      row_one   = '0;
      row_two   = '0;
      row_three = '0;
      scale     = SCALE_RESET;
    endfunction

    function void set_reg(cfg_reg_e r, logic [63:0] v);
      case (r)
        REG_ROW_ONE:   row_one   = v[47:0];
        REG_ROW_TWO:   row_two   = v[47:0];
        REG_ROW_THREE: row_three = v[47:0];
        default:       scale     = v[31:0];
      endcase
    endfunction

    function longint freq(logic [5:0] idx);
      longint k;
      k = longint'(idx);
      if (k >= 32) k = k - 64;
      return k;
    endfunction

    function logic [31:0] scale_part(logic [31:0] raw, longint unsigned g2, inout logic sat);
      longint unsigned mag, q;
      mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
      if (mag == 0) return '0;
      if (g2 == 0) begin
        sat = 1'b1;
        return raw[31] ? NEG_LIMIT : POS_LIMIT;
      end
      q = (longint'(scale) * mag) / (g2 << 8);
      if (!raw[31]) begin
        if (q > 64'h7FFF_FFFF) begin
          sat = 1'b1;
          return POS_LIMIT;
        end
        return q[31:0];
      end
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return NEG_LIMIT;
      end
      return 32'(64'h1_0000_0000 - q);
    endfunction

    // note an accepted request and predict its coefficient
    function void note(logic [87:0] req);
      coeff_t  c;
      longint  s1, s2, s3, g;
      longint unsigned g2;
      c.sat = 1'b0;
      g2 = 0;
      if (req[17:0] == 18'd0) begin
        c.re = '0;
        c.im = '0;
      end else begin
        s1 = freq(req[5:0]);
        s2 = freq(req[11:6]);
        s3 = freq(req[17:12]);
        for (int w = 0; w < 3; w++) begin
          g = s1 * longint'($signed(row_one[16*w +: 16]))
            + s2 * longint'($signed(row_two[16*w +: 16]))
            + s3 * longint'($signed(row_three[16*w +: 16]));
          g2 += longint'(g * g);
        end
        c.re = scale_part(req[49:18], g2, c.sat);
        c.im = scale_part(req[81:50], g2, c.sat);
      end
      pending.push_back(c);
    endfunction

    // compare a result with the oldest prediction; empty string when it matches
    function string check(logic [63:0] data, logic sat);
      coeff_t c;
      if (pending.size() == 0) return "result with no request outstanding";
      c = pending.pop_front();
      if (data[31:0] !== c.re)
        return $sformatf("re_out %h, predicted %h", data[31:0], c.re);
      if (data[63:32] !== c.im)
        return $sformatf("im_out %h, predicted %h", data[63:32], c.im);
      if (sat !== c.sat)
        return $sformatf("saturated %b, predicted %b", sat, c.sat);
      return "";
    endfunction
  endclass

  logic              clk_i, rst_ni;
  logic [87:0]       s_axis_tdata;
  logic              s_axis_tvalid, s_axis_tready;
  logic [63:0]       m_axis_tdata;
  logic              m_axis_tuser, m_axis_tvalid, m_axis_tready;
  logic              psel, penable, pwrite, pready;
  logic [4:0]        paddr;
  logic [63:0]       pwdata, prdata;

  poisson_board board;
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  tx_idle_pct;
  int unsigned  rx_stall_pct;

  reciprocal_poisson_scaling u_top (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("reciprocal_poisson_scaling test failed");
      $finish;
    end
  end

  // result side: check and random stalls
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      why = board.check(m_axis_tdata, m_axis_tuser);
      if (why != "") report(why);
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // register write: setup, access, then idle
  task automatic write_reg(cfg_reg_e r, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(8 * int'(r));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(r, v);
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [47:0] r1, logic [47:0] r2, logic [47:0] r3,
                           logic [31:0] sc);
    write_reg(REG_ROW_ONE, {16'd0, r1});
    write_reg(REG_ROW_TWO, {16'd0, r2});
    write_reg(REG_ROW_THREE, {16'd0, r3});
    write_reg(REG_SCALE, {32'd0, sc});
  endtask

  // send one request, with an optional random gap before it
  task automatic send(logic [5:0] a, logic [5:0] b, logic [5:0] c,
                      logic [31:0] re, logic [31:0] im);
    int unsigned gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(3, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, im, re, c, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note({6'd0, im, re, c, b, a});
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_comp(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(16'h1FFF) - 16'h1000);
      default: begin
        case ($urandom_range(4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_part();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_idx();
    case ($urandom_range(5))
      0: return 6'($urandom_range(2));
      1: return 6'(64 - $urandom_range(2, 1));
      default: return 6'($urandom);
    endcase
  endfunction

  initial begin
    logic [47:0] r[3];
    logic [31:0] sc;
    int unsigned mode;
    errors        = 0;
    cycles        = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset lattice is all zero: |G|^2 is zero off the origin
    send(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1, 0, 0, 32'd5, 32'hFFFF_FFFB);
    send(0, 0, 63, 32'd0, 32'd0);
    drain();

    // unit cubic lattice, default scale
    write_all(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000, SCALE_RESET);
    send(0, 0, 0, 32'd1, 32'd1);
    send(1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(31, 31, 31, 32'h0100_0000, 32'hFF00_0000);
    send(32, 32, 32, 32'hFFFF_FFFF, 32'd1);
    send(63, 63, 63, 32'h1234_5678, 32'h8765_4321);
    send(0, 1, 0, 32'h8000_0000, 32'd0);
    send(0, 0, 1, 32'd0, 32'h7FFF_FFFF);
    send(33, 2, 60, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    drain();

    // tiny lattice, largest scale: heavy clipping
    write_all(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000, 32'hFFFF_FFFF);
    send(1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(63, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(2, 3, 4, 32'h0000_0001, 32'hFFFF_FFFF);
    send(32, 32, 32, 32'h0001_0000, 32'hFFFF_0000);
    // zero scale
    drain();
    write_reg(REG_SCALE, 64'd0);
    send(5, 6, 7, 32'h7FFF_FFFF, 32'h8000_0000);
    send(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // random phases over several lattices and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      mode = p % 4;
      for (int j = 0; j < 3; j++)
        r[j] = {pick_comp(mode), pick_comp(mode), pick_comp(mode)};
      case (mode)
        1:       sc = 32'hFFFF_FFFF;
        3:       sc = ($urandom_range(1) == 0) ? 32'd0 : $urandom;
        default: sc = $urandom;
      endcase
      write_all(r[0], r[1], r[2], sc);
      case (p / 3)
        0: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 81;
        end
        1: begin
          tx_idle_pct  = 81;
          rx_stall_pct = 33;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        send(pick_idx(), pick_idx(), pick_idx(), pick_part(), pick_part());
      drain();
    end

    if (errors == 0) begin
      $display("reciprocal_poisson_scaling test passed");
    end else begin
      $display("reciprocal_poisson_scaling test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rps_pkg.sv
sv/reciprocal_poisson_scaling.sv
sv/rps_checker.sv
test/tb.sv
